>>> rtl/core/hhsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hhsc_pkg;

  localparam int LEN_BITS_DEF = 16;
  localparam int LIMIT_W = 16;
  localparam int BUF_LEN_W = 16;
  localparam int SEQ_W = 32;
  localparam logic [LIMIT_W-1:0] PARSE_LIMIT_RST = 16'd8192;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_H = 8'h48;

  // Length of the "HTTP/" version marker.
  localparam logic [2:0] VER_LEN = 3'd5;

  localparam int IN_TDATA_W = 40;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    VERDICT_ERROR         = 2'd0,
    VERDICT_SUCCESS       = 2'd1,
    VERDICT_REASSEMBLING  = 2'd2,
    VERDICT_SUCCESS_REASM = 2'd3
  } verdict_t;

  // Progress through a blank line: nothing, CR, CR LF, CR LF CR.
  typedef enum logic [1:0] {
    BL_IDLE   = 2'd0,
    BL_CR     = 2'd1,
    BL_CRLF   = 2'd2,
    BL_CRLFCR = 2'd3
  } blank_state_t;

  typedef struct packed {
    logic         hit;
    blank_state_t st;
  } blank_t;

  typedef struct packed {
    logic             action;
    logic [7:0]       data_byte;
    logic             first_of_packet;
    logic             last_of_packet;
    logic [SEQ_W-1:0] tcp_seq;
  } item_t;

  typedef struct packed {
    verdict_t               verdict;
    logic [BUF_LEN_W-1:0]   buffered_len;
  } result_t;

  function automatic blank_t blank_step(input blank_state_t st, input logic [7:0] b);
    blank_t r;
    r.hit = 1'b0;
    r.st  = (b == CH_CR) ? BL_CR : BL_IDLE;
    unique case (st)
      BL_IDLE: begin
      end
      BL_CR: begin
        if (b == CH_LF) r.st = BL_CRLF;
      end
      BL_CRLF: begin
        r.st = (b == CH_CR) ? BL_CRLFCR : BL_IDLE;
      end
      BL_CRLFCR: begin
        if (b == CH_LF) begin
          r.hit = 1'b1;
          r.st  = BL_IDLE;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h48;  // H
      3'd1:    c = 8'h54;  // T
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h50;  // P
      3'd4:    c = 8'h2F;  // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/http_header_stream_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies the payload of one TCP flow as HTTP, one payload byte per transaction.
// The block takes one byte every cycle while not stalled; the flow state is updated by a
// combinational loop on the registered byte, and the verdict for a packet is registered:
// its last byte enters the input register when accepted, and the verdict enters the
// result register when the output stage advances. One result transaction is produced
// for each packet's last byte; clear actions and bytes outside a packet produce none.
// The input stalls only while a finished result waits on a held-off output. The user
// must write parse_limit through the cfg port while idle; the block does not enforce this.
module http_header_stream_classifier_core #(
  parameter int LEN_BITS = hhsc_pkg::LEN_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // [7:0] data_byte, [39:8] tcp_seq
  input  wire logic [hhsc_pkg::IN_TDATA_W-1:0] in_tdata,
  // last_of_packet
  input  wire logic                            in_tlast,
  // [0] action, [1] first_of_packet
  input  wire logic [hhsc_pkg::IN_TUSER_W-1:0] in_tuser,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // [1:0] verdict, [17:2] buffered_len, [23:18] zero
  output      logic [hhsc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [hhsc_pkg::LIMIT_W-1:0]    cfg_data
);
  import hhsc_pkg::*;

  logic               advance;
  logic               item_valid;
  item_t              item;
  logic               res_valid;
  result_t            res;
  logic [LIMIT_W-1:0] parse_limit_r;
  logic [LIMIT_W-1:0] parse_limit_nxt;

  assign cfg_ready       = 1'b1;
  assign parse_limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : parse_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_limit_r <= PARSE_LIMIT_RST;
    end else begin
      parse_limit_r <= parse_limit_nxt;
    end
  end

  hhsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hhsc_flow #(
    .LEN_BITS (LEN_BITS)
  ) u_flow (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (item_valid && advance),
    .item        (item),
    .parse_limit (parse_limit_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  hhsc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/hhsc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hhsc_in_stage (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [hhsc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                           in_tlast,
  input  wire logic [hhsc_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                           advance,
  output      logic                           item_valid,
  output      hhsc_pkg::item_t                item
);
  import hhsc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    item_nxt                 = item_r;
    valid_nxt                = valid_r && !advance;
    if (take) begin
      valid_nxt              = 1'b1;
      item_nxt.action          = in_tuser[0];
      item_nxt.first_of_packet = in_tuser[1];
      item_nxt.data_byte       = in_tdata[7:0];
      item_nxt.tcp_seq         = in_tdata[8 +: SEQ_W];
      item_nxt.last_of_packet  = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> rtl/core/hhsc_flow.sv
`timescale 1ns / 1ps
`default_nettype none

module hhsc_flow #(
  parameter int LEN_BITS = hhsc_pkg::LEN_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire hhsc_pkg::item_t              item,
  input  wire logic [hhsc_pkg::LIMIT_W-1:0] parse_limit,
  output      logic                         res_valid,
  output      hhsc_pkg::result_t            res
);
  import hhsc_pkg::*;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  logic                flow_is_http_r, flow_is_http_nxt;
  logic                have_frag_r, have_frag_nxt;
  logic [LEN_BITS-1:0] stream_len_r, stream_len_nxt;
  logic [SEQ_W-1:0]    expected_seq_r, expected_seq_nxt;
  logic                cont_r, cont_nxt;
  logic [LEN_BITS-1:0] packet_len_r, packet_len_nxt;
  logic [SEQ_W-1:0]    packet_seq_r, packet_seq_nxt;
  logic                crlf_seen_r, crlf_seen_nxt;
  logic                prev_cr_r, prev_cr_nxt;
  logic                ver_seen_r, ver_seen_nxt;
  logic [2:0]          ver_match_r, ver_match_nxt;
  blank_state_t        pblank_r, pblank_nxt;
  logic                pblank_found_r, pblank_found_nxt;
  blank_state_t        sblank_r, sblank_nxt;
  logic                sblank_found_r, sblank_found_nxt;
  logic                in_packet_r, in_packet_nxt;
  blank_state_t        pend_r, pend_nxt;
  logic                pend_found_r, pend_found_nxt;

  logic [LEN_BITS:0]   len_sum;
  logic [LEN_BITS-1:0] new_stream_len;
  logic [2:0]          vm;
  logic [7:0]          b;
  blank_t              pstep;
  blank_t              sstep;
  logic                clear;
  logic                byte_live;

  assign b       = item.data_byte;
  assign clear   = en && item.action;
  assign byte_live = en && !item.action && (item.first_of_packet || in_packet_r);

  always_comb begin
    flow_is_http_nxt = flow_is_http_r;
    have_frag_nxt    = have_frag_r;
    stream_len_nxt   = stream_len_r;
    expected_seq_nxt = expected_seq_r;
    cont_nxt         = cont_r;
    packet_len_nxt   = packet_len_r;
    packet_seq_nxt   = packet_seq_r;
    crlf_seen_nxt    = crlf_seen_r;
    prev_cr_nxt      = prev_cr_r;
    ver_seen_nxt     = ver_seen_r;
    ver_match_nxt    = ver_match_r;
    pblank_nxt       = pblank_r;
    pblank_found_nxt = pblank_found_r;
    sblank_nxt       = sblank_r;
    sblank_found_nxt = sblank_found_r;
    in_packet_nxt    = in_packet_r;
    pend_nxt         = pend_r;
    pend_found_nxt   = pend_found_r;
    vm               = 3'd0;
    pstep            = '0;
    sstep            = '0;
    len_sum          = '0;
    new_stream_len   = stream_len_r;
    res_valid        = 1'b0;
    res.verdict      = VERDICT_ERROR;
    res.buffered_len = BUF_LEN_W'(SEQ_W'(stream_len_r));

    if (byte_live) begin
      // A first mark restarts the per-packet state, even inside an open packet.
      if (item.first_of_packet) begin
        in_packet_nxt    = 1'b1;
        packet_seq_nxt   = item.tcp_seq;
        packet_len_nxt   = '0;
        cont_nxt         = flow_is_http_r && (stream_len_r != '0) &&
                           (item.tcp_seq == expected_seq_r);
        crlf_seen_nxt    = 1'b0;
        prev_cr_nxt      = 1'b0;
        ver_seen_nxt     = 1'b0;
        ver_match_nxt    = 3'd0;
        pblank_nxt       = BL_IDLE;
        pblank_found_nxt = 1'b0;
        pend_nxt         = sblank_r;
        pend_found_nxt   = sblank_found_r;
      end

      if (packet_len_nxt != LEN_MAX) packet_len_nxt = packet_len_nxt + 1'b1;

      // The version marker only counts when it lies wholly before the first CRLF.
      if (!crlf_seen_nxt) begin
        if (prev_cr_nxt && (b == CH_LF)) begin
          crlf_seen_nxt = 1'b1;
        end else if (!ver_seen_nxt) begin
          vm = ver_match_nxt;
          if (b == ver_char(vm)) vm = vm + 3'd1;
          else vm = (b == CH_H) ? 3'd1 : 3'd0;
          if (vm == VER_LEN) begin
            ver_seen_nxt = 1'b1;
            vm           = 3'd0;
          end
          ver_match_nxt = vm;
        end
      end
      prev_cr_nxt = (b == CH_CR);

      pstep      = blank_step(pblank_nxt, b);
      pblank_nxt = pstep.st;
      if (pstep.hit) pblank_found_nxt = 1'b1;
      sstep    = blank_step(pend_nxt, b);
      pend_nxt = sstep.st;
      if (sstep.hit) pend_found_nxt = 1'b1;

      if (item.last_of_packet) begin
        in_packet_nxt = 1'b0;
        res_valid     = 1'b1;
        if (!cont_nxt && (!crlf_seen_nxt || !ver_seen_nxt)) begin
          res.verdict = VERDICT_ERROR;
        end else if (!cont_nxt && pblank_found_nxt) begin
          res.verdict = VERDICT_SUCCESS;
        end else begin
          len_sum          = {1'b0, stream_len_r} + {1'b0, packet_len_nxt};
          new_stream_len   = len_sum[LEN_BITS] ? LEN_MAX : len_sum[LEN_BITS-1:0];
          have_frag_nxt    = 1'b1;
          flow_is_http_nxt = 1'b1;
          stream_len_nxt   = new_stream_len;
          expected_seq_nxt = packet_seq_nxt + SEQ_W'(packet_len_nxt);
          sblank_nxt       = pend_nxt;
          sblank_found_nxt = pend_found_nxt;
          res.buffered_len = BUF_LEN_W'(SEQ_W'(new_stream_len));
          if (SEQ_W'(new_stream_len) >= SEQ_W'(parse_limit)) begin
            res.verdict = VERDICT_ERROR;
          end else if (pend_found_nxt) begin
            res.verdict = VERDICT_SUCCESS_REASM;
          end else begin
            res.verdict = VERDICT_REASSEMBLING;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      flow_is_http_r <= 1'b0;
      have_frag_r    <= 1'b0;
      stream_len_r   <= '0;
      expected_seq_r <= '0;
      cont_r         <= 1'b0;
      packet_len_r   <= '0;
      packet_seq_r   <= '0;
      crlf_seen_r    <= 1'b0;
      prev_cr_r      <= 1'b0;
      ver_seen_r     <= 1'b0;
      ver_match_r    <= 3'd0;
      pblank_r       <= BL_IDLE;
      pblank_found_r <= 1'b0;
      sblank_r       <= BL_IDLE;
      sblank_found_r <= 1'b0;
      in_packet_r    <= 1'b0;
      pend_r         <= BL_IDLE;
      pend_found_r   <= 1'b0;
    end else begin
      flow_is_http_r <= flow_is_http_nxt;
      have_frag_r    <= have_frag_nxt;
      stream_len_r   <= stream_len_nxt;
      expected_seq_r <= expected_seq_nxt;
      cont_r         <= cont_nxt;
      packet_len_r   <= packet_len_nxt;
      packet_seq_r   <= packet_seq_nxt;
      crlf_seen_r    <= crlf_seen_nxt;
      prev_cr_r      <= prev_cr_nxt;
      ver_seen_r     <= ver_seen_nxt;
      ver_match_r    <= ver_match_nxt;
      pblank_r       <= pblank_nxt;
      pblank_found_r <= pblank_found_nxt;
      sblank_r       <= sblank_nxt;
      sblank_found_r <= sblank_found_nxt;
      in_packet_r    <= in_packet_nxt;
      pend_r         <= pend_nxt;
      pend_found_r   <= pend_found_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hhsc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hhsc_out_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire hhsc_pkg::result_t                res,
  output      logic                             advance,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [hhsc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hhsc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  result_t res_nxt;

  // The register may be refilled in the same cycle its transaction completes.
  assign advance = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r && !out_tready;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - BUF_LEN_W - 2){1'b0}}, res_r.buffered_len,
                       res_r.verdict};

endmodule

`default_nettype wire

>>> rtl/core/hhsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hhsc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [hhsc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hhsc_pkg::*;

  // No result may be pending right after a reset cycle.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The input only backs up when a finished result is held off downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output backlog");

  // A reassembly verdict lies below the limit and adds a packet's bytes, so its stream length is nonzero.
  a_reasm_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((out_tdata[1:0] == VERDICT_REASSEMBLING) ||
                    (out_tdata[1:0] == VERDICT_SUCCESS_REASM)))
    |-> (out_tdata[17:2] != '0))
    else $error("reassembly verdict with empty stream");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result transaction changed");

endmodule

bind http_header_stream_classifier_core hhsc_checker u_hhsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> test/http_header_stream_classifier_core_tb.sv
`timescale 1ns / 1ps

module http_header_stream_classifier_core_tb;
  import hhsc_pkg::*;

  // Expected verdicts for one flow, worked out byte by byte.
  class hhsc_flow_tracker;
    logic [LIMIT_W-1:0]   parse_limit;
    bit                   flow_is_http, have_fragments, continuing, pkt_open;
    logic [BUF_LEN_W-1:0] stream_len, pkt_len;
    logic [SEQ_W-1:0]     expected_seq, pkt_seq;
    bit                   crlf_seen, prev_cr, version_seen;
    int unsigned          version_pos;
    blank_state_t         pkt_blank, stream_blank, pend_blank;
    bit                   pkt_blank_found, stream_blank_found, pend_found;
    result_t              verdict_q[$];
    int unsigned          mismatches;
    string                version_text;

    function new();
      parse_limit  = PARSE_LIMIT_RST;
      mismatches   = 0;
      version_text = "HTTP/";
      clear_flow();
    endfunction

    function void clear_flow();
      flow_is_http = 0; have_fragments = 0; continuing = 0; pkt_open = 0;
      stream_len = '0; pkt_len = '0; expected_seq = '0; pkt_seq = '0;
      crlf_seen = 0; prev_cr = 0; version_seen = 0; version_pos = 0;
      pkt_blank = BL_IDLE; stream_blank = BL_IDLE; pend_blank = BL_IDLE;
      pkt_blank_found = 0; stream_blank_found = 0; pend_found = 0;
    endfunction

    function blank_state_t blank_next(blank_state_t st, logic [7:0] b, output bit hit);
      hit = 0;
      case (st)
        BL_CR: begin
          if (b == CH_LF) return BL_CRLF;
        end
        BL_CRLF: begin
          return (b == CH_CR) ? BL_CRLFCR : BL_IDLE;
        end
        BL_CRLFCR: begin
          if (b == CH_LF) begin
            hit = 1;
            return BL_IDLE;
          end
        end
        default: begin
        end
      endcase
      return (b == CH_CR) ? BL_CR : BL_IDLE;
    endfunction

    // Returns 0 when the byte is ignored by the block.
    function bit note_byte(bit action, logic [7:0] b, bit is_first, bit is_last,
                           logic [SEQ_W-1:0] seq);
      bit                 hit;
      logic [BUF_LEN_W:0] sum;
      result_t            res;
      if (action) begin
        clear_flow();
        return 1;
      end
      if (is_first) begin
        pkt_open = 1;
        pkt_seq = seq;
        pkt_len = '0;
        continuing = flow_is_http && (stream_len != 0) && (seq == expected_seq);
        crlf_seen = 0; prev_cr = 0; version_seen = 0; version_pos = 0;
        pkt_blank = BL_IDLE; pkt_blank_found = 0;
        pend_blank = stream_blank; pend_found = stream_blank_found;
      end else if (!pkt_open) begin
        return 0;
      end

      if (pkt_len != '1) pkt_len++;

      if (!crlf_seen) begin
        if (prev_cr && b == CH_LF) begin
          crlf_seen = 1;
        end else if (!version_seen) begin
          if (b == version_text[version_pos]) version_pos++;
          else version_pos = (b == CH_H) ? 1 : 0;
          if (version_pos >= 5) begin
            version_seen = 1;
            version_pos = 0;
          end
        end
      end
      prev_cr = (b == CH_CR);

      pkt_blank = blank_next(pkt_blank, b, hit);
      if (hit) pkt_blank_found = 1;
      pend_blank = blank_next(pend_blank, b, hit);
      if (hit) pend_found = 1;

      if (!is_last) return 1;
      pkt_open = 0;

      if (!continuing && (!crlf_seen || !version_seen)) begin
        res.verdict = VERDICT_ERROR;
      end else if (!continuing && pkt_blank_found) begin
        res.verdict = VERDICT_SUCCESS;
      end else begin
        sum = {1'b0, stream_len} + {1'b0, pkt_len};
        if (!have_fragments) begin
          have_fragments = 1;
          flow_is_http = 1;
        end
        stream_len = sum[BUF_LEN_W] ? '1 : sum[BUF_LEN_W-1:0];
        expected_seq = pkt_seq + SEQ_W'(pkt_len);
        stream_blank = pend_blank;
        stream_blank_found = pend_found;
        if (stream_len >= parse_limit) res.verdict = VERDICT_ERROR;
        else if (stream_blank_found) res.verdict = VERDICT_SUCCESS_REASM;
        else res.verdict = VERDICT_REASSEMBLING;
      end
      res.buffered_len = stream_len;
      verdict_q.push_back(res);
      return 1;
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      result_t got, want;
      got.verdict = verdict_t'(tdata[1:0]);
      got.buffered_len = tdata[17:2];
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict %s len %0d", got.verdict.name(), got.buffered_len);
        return;
      end
      want = verdict_q.pop_front();
      if (got.verdict !== want.verdict || got.buffered_len !== want.buffered_len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict mismatch: expected %s len %0d, got %s len %0d",
                   want.verdict.name(), want.buffered_len,
                   got.verdict.name(), got.buffered_len);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LIMIT_W-1:0]     cfg_data = '0;

  hhsc_flow_tracker flow = new();
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;
  int               items_done = 0;

  http_header_stream_classifier_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) flow.check_result(out_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
      end else if (stall_left == 0 && idle_on) begin
        r = $urandom_range(0, 99);
        if (r < 6) stall_left = $urandom_range(1, 3);
        else if (r < 8) stall_left = $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(bit action, logic [7:0] b, bit is_first, bit is_last,
                           logic [SEQ_W-1:0] seq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {seq, b};
    in_tlast  <= is_last;
    in_tuser  <= {is_first, action};
    do @(posedge clk); while (!in_tready);
    if (flow.note_byte(action, b, is_first, is_last, seq)) items_done++;
  endtask

  task automatic send_clear();
    send_item(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), $urandom());
  endtask

  // The sequence number only matters on the first byte, so the rest carry noise.
  task automatic send_packet(ref logic [7:0] q[$], input logic [SEQ_W-1:0] seq,
                             input bit close);
    for (int i = 0; i < q.size(); i++)
      send_item(1'b0, q[i], i == 0, close && (i == q.size() - 1),
                (i == 0) ? seq : $urandom());
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (flow.verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    flow.parse_limit = value;
  endtask

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Mostly lowercase, with the version letters and CR mixed in to disturb the matcher.
  function automatic void add_letters(ref logic [7:0] q[$], input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: q.push_back("H");
        1: q.push_back("T");
        2: q.push_back("/");
        3: q.push_back(CH_CR);
        default: q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      endcase
    end
  endfunction

  function automatic void make_header(ref logic [7:0] q[$], input bit complete);
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: add_text(q, "HTTP/1.1 200 OK\r\n");
      1: add_text(q, "HEAD /HT HTTP/1.0\r\n");
      2: add_text(q, "POST /HTTHTTP/ x\r\n");
      3: add_text(q, "GET\r\n/ HTTP/1.1\r\n");
      4: add_text(q, "GET / HTTP1.1\r\n");
      default: begin
        add_text(q, "GET /");
        add_letters(q, $urandom_range(0, 6));
        add_text(q, " HTTP/1.1\r\n");
      end
    endcase
    repeat ($urandom_range(0, 3)) begin
      add_text(q, "X-");
      add_letters(q, $urandom_range(1, 8));
      add_text(q, "\r\n");
    end
    if (complete) add_text(q, "\r\n");
  endfunction

  // A header sent as one or more segments, now and then with a broken sequence, a clear or an unclosed segment.
  task automatic http_session();
    logic [7:0]       hdr[$];
    logic [7:0]       frag[$];
    logic [SEQ_W-1:0] seq;
    int               pos, len, frags_left, r;
    if ($urandom_range(0, 99) < 40) send_clear();
    make_header(hdr, $urandom_range(0, 99) < 85);
    seq = $urandom();
    pos = 0;
    frags_left = $urandom_range(1, 4);
    while (pos < hdr.size()) begin
      len = (frags_left > 1) ? $urandom_range(1, hdr.size() - pos) : hdr.size() - pos;
      frag = hdr[pos : pos + len - 1];
      r = $urandom_range(0, 99);
      if (r < 4) send_clear();
      send_packet(frag, (r >= 4 && r < 10) ? seq ^ (32'd1 << $urandom_range(0, 31)) : seq,
                  !(r >= 10 && r < 14));
      seq += len;
      pos += len;
      frags_left--;
    end
  endtask

  task automatic noise_packet();
    logic [7:0] q[$];
    int         r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 5);
      case (r)
        0: q.push_back(CH_CR);
        1: q.push_back(CH_LF);
        2: q.push_back(CH_H);
        default: q.push_back(8'($urandom));
      endcase
    end
    send_packet(q, ($urandom_range(0, 4) == 0) ? flow.expected_seq : $urandom(), 1'b1);
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) send_clear();
    else if (r < 18) noise_packet();
    else if (r < 22) send_item(1'b0, 8'($urandom), 1'b0, 1'($urandom), $urandom());
    else http_session();
  endtask

  initial begin : stimulus
    logic [7:0]         q[$];
    logic [LIMIT_W-1:0] limits[5];
    int                 target;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset limit.
    send_item(1'b0, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_item(1'b0, 8'h00, 1'b1, 1'b1, 32'h0);
    q = {}; add_text(q, "HTTP/\r\n\r\n");
    send_packet(q, 32'hFFFF_FFFF, 1'b1);
    // A blank line split over two segments, with a wrapping sequence number.
    q = {}; add_text(q, "HTTP/\r\n");
    send_packet(q, 32'hFFFF_FFFC, 1'b1);
    q = {}; add_text(q, "\r\n");
    send_packet(q, 32'h3, 1'b1);
    q = {}; add_text(q, "HT");
    send_packet(q, 32'h1234_5678, 1'b0);
    q = {}; add_text(q, "HTTP/\r\nX");
    send_packet(q, 32'h0, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    q = {}; add_text(q, "\r\nHTTP/");
    send_packet(q, 32'h5, 1'b1);

    write_limit(16'd0);
    q = {}; add_text(q, "HTTP/\r\n");
    send_packet(q, 32'h8000_0000, 1'b1);
    send_clear();

    limits = '{16'hFFFF, 16'd1, 16'($urandom_range(40, 400)), PARSE_LIMIT_RST,
               16'($urandom_range(1, 65535))};
    target = items_done;
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      idle_on = (p != 2);
      if (p == 0) hold_req = 1'b1;
      target += 320;
      while (items_done < target) random_step();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (flow.verdict_q.size() != 0) begin
      $display("%0d verdicts never arrived", flow.verdict_q.size());
      flow.mismatches += flow.verdict_q.size();
    end
    if (flow.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
